### hw/rtl/itdq_pkg.sv
package itdq_pkg;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int DIST_W   = 12;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_CLEAR = 2'd0;
  localparam op_t OP_ADD   = 2'd1;
  localparam op_t OP_QUERY = 2'd2;
  localparam op_t OP_RSVD  = 2'd3;

  localparam status_t STATUS_OK   = 2'd0;
  localparam status_t STATUS_FULL = 2'd1;
  localparam status_t STATUS_BAD  = 2'd2;

endpackage

### hw/rtl/interval_tree_distance_query_top.sv
// interval containment tree with distance queries
// command channel: present operation, coord_a, coord_b with start high; the
// transfer happens at the clock edge where start is high and busy is low.
// busy stays high until the result is out. every command gives exactly one
// result: done is high for one cycle with distance and status valid; the
// receiver cannot stall, so the result must be taken in that cycle.
// clear, the unused code and a refused add finish straight from idle. a stored
// add examines stack entries, popping each that does not contain it, writes the
// endpoints, the depth and the first jump level, then builds the rest of the
// jump row one level per read-modify-write of the jump memory.
// a query locates each point by binary search over the left endpoints and
// then lifting, reads both depths, climbs the deeper node by one jump per
// set bit of the depth gap, compares the two nodes and, if they differ,
// lifts both to meet at the common ancestor. all of it is paced by the
// single read port of the jump and endpoint memories.
// reset (synchronous, active high) empties the table; the memories are not
// swept, the root entries are supplied by logic, so a command can be taken
// in the first cycle after reset.
module interval_tree_distance_query_top #(
  parameter int MAX_INTERVALS = 1024,
  parameter int LIFT_LEVELS   = 11,
  parameter int COORD_BITS    = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [itdq_pkg::OP_W-1:0]     operation,
  input  logic [COORD_BITS-1:0]         coord_a,
  input  logic [COORD_BITS-1:0]         coord_b,
  output logic                          done,
  output logic [itdq_pkg::DIST_W-1:0]   distance,
  output logic [itdq_pkg::STATUS_W-1:0] status
);

  localparam int NB = $clog2(MAX_INTERVALS + 1);
  localparam int IB = $clog2(MAX_INTERVALS);
  localparam int KB = $clog2(LIFT_LEVELS);
  localparam int JD = (MAX_INTERVALS + 1) << KB;
  localparam int DW = itdq_pkg::DIST_W;
  localparam logic [KB-1:0] LVL_TOP = KB'(LIFT_LEVELS - 1);
  localparam logic [NB-1:0] MAX_N   = NB'(MAX_INTERVALS);

  typedef enum logic [4:0] {
    S_IDLE, S_POP, S_POP_T, S_POP_CMP, S_ADD_WR, S_ADD_DEP, S_ADD_JRD, S_ADD_JWR,
    S_LOC, S_LOC_CMP, S_LOC_R, S_LIFT_J, S_LIFT_Y, S_LIFT_R, S_LIFT_FIN, S_LIFT_FW,
    S_LOC_END, S_DEP_A, S_DEP_AW, S_DEP_BW, S_UP, S_UP_W, S_CMP, S_DN, S_DN_A,
    S_DN_B
  } state_t;

  state_t state;

  logic [COORD_BITS-1:0] pa, pb, p_cur, last_l, last_r;
  logic [NB-1:0] count, stack_top, par, tnode, jprev;
  logic [NB-1:0] lo, hi, x, y, na, nb, a_n, b_n, ja, da, gap;
  logic [KB-1:0] lvl;
  logic          loc_sel, jz, dz;
  logic [DW-1:0] res;

  logic [NB-1:0] node, mid, jval, dval;
  logic          gap_bit;

  // memory ports
  logic                  lr_we, st_we, dp_we, jp_we;
  logic [IB-1:0]         lr_wa, l_ra, r_ra;
  logic [COORD_BITS-1:0] l_rd, r_rd;
  logic [NB-1:0]         st_wa, st_ra, st_wd, st_rd;
  logic [NB-1:0]         dp_wa, dp_ra, dp_wd, dp_rd;
  logic [NB-1:0]         j_node, jw_node, jp_wd, jp_rd;
  logic [KB-1:0]         j_lvl, jw_lvl;

  function automatic logic gap_bit_of(input logic [NB-1:0] g, input logic [KB-1:0] k);
    logic [NB-1:0] s;
    s = g >> k;
    return s[0];
  endfunction

  assign node    = NB'(count + 1'b1);
  assign mid     = NB'(lo + ((hi - lo) >> 1));
  assign jval    = jz ? '0 : jp_rd;
  assign dval    = dz ? '0 : dp_rd;
  assign gap_bit = gap_bit_of(gap, lvl);
  assign busy    = (state != S_IDLE);

  always_comb begin
    lr_we   = 1'b0;
    lr_wa   = count[IB-1:0];
    l_ra    = mid[IB-1:0];
    r_ra    = IB'(lo - 1'b1);
    st_we   = 1'b0;
    st_wa   = NB'(stack_top + 1'b1);
    st_wd   = node;
    st_ra   = stack_top;
    dp_we   = 1'b0;
    dp_wa   = node;
    dp_wd   = NB'(dval + 1'b1);
    dp_ra   = par;
    jp_we   = 1'b0;
    jw_node = node;
    jw_lvl  = lvl;
    jp_wd   = jval;
    j_node  = x;
    j_lvl   = lvl;
    unique case (state)
      S_POP_T: begin
        l_ra = IB'(st_rd - 1'b1);
        r_ra = IB'(st_rd - 1'b1);
      end
      S_ADD_WR: lr_we = 1'b1;
      S_ADD_DEP: begin
        dp_we  = 1'b1;
        jp_we  = 1'b1;
        jw_lvl = '0;
        jp_wd  = par;
      end
      S_ADD_JRD: begin
        j_node = jprev;
        j_lvl  = KB'(lvl - 1'b1);
      end
      S_ADD_JWR: begin
        jp_we = 1'b1;
        st_we = (lvl == LVL_TOP);
      end
      S_LIFT_Y: r_ra = IB'(jval - 1'b1);
      S_LIFT_FIN: j_lvl = '0;
      S_DEP_A: dp_ra = na;
      S_DEP_AW: dp_ra = nb;
      S_UP: j_node = b_n;
      S_DN: j_node = a_n;
      S_DN_A: j_node = b_n;
      default: ;
    endcase
  end

  itdq_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_INTERVALS)) u_left (
    .clk(clk), .we(lr_we), .waddr(lr_wa), .wdata(pa), .raddr(l_ra), .rdata(l_rd)
  );

  itdq_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_INTERVALS)) u_right (
    .clk(clk), .we(lr_we), .waddr(lr_wa), .wdata(pb), .raddr(r_ra), .rdata(r_rd)
  );

  itdq_ram #(.WIDTH(NB), .DEPTH(MAX_INTERVALS + 1)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd)
  );

  itdq_ram #(.WIDTH(NB), .DEPTH(MAX_INTERVALS + 1)) u_depth (
    .clk(clk), .we(dp_we), .waddr(dp_wa), .wdata(dp_wd), .raddr(dp_ra), .rdata(dp_rd)
  );

  itdq_ram #(.WIDTH(NB), .DEPTH(JD)) u_jump (
    .clk(clk), .we(jp_we), .waddr({jw_node, jw_lvl}), .wdata(jp_wd),
    .raddr({j_node, j_lvl}), .rdata(jp_rd)
  );

  always_ff @(posedge clk) begin
    // root rows are all zero and never stored
    jz   <= (j_node == '0);
    dz   <= (dp_ra == '0);
    done <= 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      stack_top <= '0;
      distance  <= '0;
      status    <= itdq_pkg::STATUS_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            pa       <= coord_a;
            pb       <= coord_b;
            distance <= '0;
            status   <= itdq_pkg::STATUS_OK;
            case (operation)
              itdq_pkg::OP_CLEAR: begin
                count     <= '0;
                stack_top <= '0;
                done      <= 1'b1;
              end
              itdq_pkg::OP_ADD: begin
                if (coord_a > coord_b || (count != '0 && (coord_a < last_l ||
                    (coord_a == last_l && coord_b < last_r)))) begin
                  status <= itdq_pkg::STATUS_BAD;
                  done   <= 1'b1;
                end else if (count >= MAX_N) begin
                  status <= itdq_pkg::STATUS_FULL;
                  done   <= 1'b1;
                end else if (stack_top == '0) begin
                  par   <= '0;
                  state <= S_ADD_WR;
                end else begin
                  state <= S_POP;
                end
              end
              itdq_pkg::OP_QUERY: begin
                loc_sel <= 1'b0;
                p_cur   <= coord_a;
                lo      <= '0;
                hi      <= count;
                state   <= S_LOC;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_POP: state <= S_POP_T;
        S_POP_T: begin
          tnode <= st_rd;
          state <= S_POP_CMP;
        end
        S_POP_CMP: begin
          if (l_rd <= pa && pb <= r_rd) begin
            par   <= tnode;
            state <= S_ADD_WR;
          end else begin
            stack_top <= NB'(stack_top - 1'b1);
            if (stack_top == NB'(1)) begin
              par   <= '0;
              state <= S_ADD_WR;
            end else begin
              state <= S_POP;
            end
          end
        end
        S_ADD_WR: state <= S_ADD_DEP;
        S_ADD_DEP: begin
          jprev <= par;
          lvl   <= KB'(1);
          state <= S_ADD_JRD;
        end
        S_ADD_JRD: state <= S_ADD_JWR;
        S_ADD_JWR: begin
          jprev <= jval;
          if (lvl == LVL_TOP) begin
            stack_top <= NB'(stack_top + 1'b1);
            count     <= node;
            last_l    <= pa;
            last_r    <= pb;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else begin
            lvl   <= KB'(lvl + 1'b1);
            state <= S_ADD_JRD;
          end
        end
        S_LOC: begin
          if (lo < hi) begin
            state <= S_LOC_CMP;
          end else begin
            x     <= lo;
            state <= (lo != '0) ? S_LOC_R : S_LOC_END;
          end
        end
        S_LOC_CMP: begin
          if (l_rd <= p_cur) begin
            lo <= NB'(mid + 1'b1);
          end else begin
            hi <= mid;
          end
          state <= S_LOC;
        end
        S_LOC_R: begin
          if (r_rd < p_cur) begin
            lvl   <= LVL_TOP;
            state <= S_LIFT_J;
          end else begin
            state <= S_LOC_END;
          end
        end
        S_LIFT_J: state <= S_LIFT_Y;
        S_LIFT_Y: begin
          y <= jval;
          if (jval != '0) begin
            state <= S_LIFT_R;
          end else if (lvl == '0) begin
            state <= S_LIFT_FIN;
          end else begin
            lvl   <= KB'(lvl - 1'b1);
            state <= S_LIFT_J;
          end
        end
        S_LIFT_R: begin
          if (r_rd < p_cur) begin
            x <= y;
          end
          if (lvl == '0) begin
            state <= S_LIFT_FIN;
          end else begin
            lvl   <= KB'(lvl - 1'b1);
            state <= S_LIFT_J;
          end
        end
        S_LIFT_FIN: state <= S_LIFT_FW;
        S_LIFT_FW: begin
          x     <= jval;
          state <= S_LOC_END;
        end
        S_LOC_END: begin
          if (!loc_sel) begin
            na      <= x;
            loc_sel <= 1'b1;
            p_cur   <= pb;
            lo      <= '0;
            hi      <= count;
            state   <= S_LOC;
          end else begin
            nb    <= x;
            state <= S_DEP_A;
          end
        end
        S_DEP_A: state <= S_DEP_AW;
        S_DEP_AW: begin
          da    <= dval;
          state <= S_DEP_BW;
        end
        S_DEP_BW: begin
          if (da > dval) begin
            a_n <= nb;
            b_n <= na;
            gap <= NB'(da - dval);
          end else begin
            a_n <= na;
            b_n <= nb;
            gap <= NB'(dval - da);
          end
          res   <= '0;
          lvl   <= '0;
          state <= S_UP;
        end
        S_UP: begin
          if (gap_bit) begin
            state <= S_UP_W;
          end else if (lvl == LVL_TOP) begin
            state <= S_CMP;
          end else begin
            lvl <= KB'(lvl + 1'b1);
          end
        end
        S_UP_W: begin
          b_n <= jval;
          res <= DW'(res + (DW'(1) << lvl));
          if (lvl == LVL_TOP) begin
            state <= S_CMP;
          end else begin
            lvl   <= KB'(lvl + 1'b1);
            state <= S_UP;
          end
        end
        S_CMP: begin
          if (a_n == b_n) begin
            distance <= res;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            lvl   <= LVL_TOP;
            state <= S_DN;
          end
        end
        S_DN: state <= S_DN_A;
        S_DN_A: begin
          ja    <= jval;
          state <= S_DN_B;
        end
        S_DN_B: begin
          if (ja != jval) begin
            a_n <= ja;
            b_n <= jval;
            res <= DW'(res + (DW'(2) << lvl));
          end
          if (lvl == '0) begin
            if (ja != jval) begin
              distance <= DW'(res + (DW'(2) << lvl) + DW'(2));
            end else begin
              distance <= DW'(res + DW'(2));
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            lvl   <= KB'(lvl - 1'b1);
            state <= S_DN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/itdq_ram.sv
module itdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sim/itdq_checker.sv
`timescale 1ns / 1ps
module itdq_checker #(
  parameter int MAX_INTERVALS = 1024,
  parameter int LIFT_LEVELS   = 11,
  parameter int COORD_BITS    = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [itdq_pkg::OP_W-1:0]     operation,
  input  logic [COORD_BITS-1:0]         coord_a,
  input  logic [COORD_BITS-1:0]         coord_b,
  input  logic                          done,
  input  logic [itdq_pkg::DIST_W-1:0]   distance,
  input  logic [itdq_pkg::STATUS_W-1:0] status,
  output int                            fail_count,
  output int                            pending,
  output int                            results_seen
);

  localparam int DW = itdq_pkg::DIST_W;

  typedef struct packed {
    logic [itdq_pkg::DIST_W-1:0]   edges;
    logic [itdq_pkg::STATUS_W-1:0] stat;
  } answer_t;

  logic [COORD_BITS-1:0] lefts  [MAX_INTERVALS];
  logic [COORD_BITS-1:0] rights [MAX_INTERVALS];
  int unsigned depths [MAX_INTERVALS+1];
  int unsigned jumps  [MAX_INTERVALS+1][LIFT_LEVELS];
  int unsigned nest   [MAX_INTERVALS+1];
  int unsigned nest_top;
  int unsigned n_stored;
  answer_t answers_due[$];

  task automatic report(input string what);
    $display("itdq_checker: mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic int unsigned deepest_holder(input logic [COORD_BITS-1:0] p);
    int unsigned lo, hi, mid, x, y;
    lo = 0;
    hi = n_stored;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (lefts[mid] <= p) lo = mid + 1; else hi = mid;
    end
    x = lo;
    if (x != 0 && rights[x-1] < p) begin
      for (int k = LIFT_LEVELS - 1; k >= 0; k--) begin
        y = jumps[x][k];
        if (y != 0 && rights[y-1] < p) x = y;
      end
      x = jumps[x][0];
    end
    return x;
  endfunction

  function automatic int unsigned edges_between(input int unsigned a, input int unsigned b);
    int unsigned t, gap, res;
    if (depths[a] > depths[b]) begin
      t = a; a = b; b = t;
    end
    gap = depths[b] - depths[a];
    res = 0;
    for (int k = 0; k < LIFT_LEVELS; k++) begin
      if ((gap >> k) & 1) begin
        b = jumps[b][k];
        res += 1 << k;
      end
    end
    if (a == b) return res;
    for (int k = LIFT_LEVELS - 1; k >= 0; k--) begin
      if (jumps[a][k] != jumps[b][k]) begin
        a = jumps[a][k];
        b = jumps[b][k];
        res += 2 << k;
      end
    end
    return res + 2;
  endfunction

  function automatic itdq_pkg::status_t insert_interval(input logic [COORD_BITS-1:0] l,
                                                        input logic [COORD_BITS-1:0] r);
    int unsigned t, node, par;
    if (l > r) return itdq_pkg::STATUS_BAD;
    if (n_stored > 0) begin
      if (l < lefts[n_stored-1] || (l == lefts[n_stored-1] && r < rights[n_stored-1]))
        return itdq_pkg::STATUS_BAD;
    end
    if (n_stored >= MAX_INTERVALS) return itdq_pkg::STATUS_FULL;
    while (nest_top > 0) begin
      t = nest[nest_top];
      if (lefts[t-1] <= l && r <= rights[t-1]) break;
      nest_top--;
    end
    node = n_stored + 1;
    par = nest[nest_top];
    lefts[node-1] = l;
    rights[node-1] = r;
    depths[node] = depths[par] + 1;
    jumps[node][0] = par;
    for (int k = 1; k < LIFT_LEVELS; k++) jumps[node][k] = jumps[jumps[node][k-1]][k-1];
    nest_top++;
    nest[nest_top] = node;
    n_stored = node;
    return itdq_pkg::STATUS_OK;
  endfunction

  initial begin
    fail_count = 0;
    results_seen = 0;
    pending = 0;
    n_stored = 0;
    nest_top = 0;
    nest[0] = 0;
    depths[0] = 0;
    for (int k = 0; k < LIFT_LEVELS; k++) jumps[0][k] = 0;
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst) begin
      if (done) begin
        results_seen++;
        if (answers_due.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = answers_due.pop_front();
          if (distance !== want.edges)
            report($sformatf("distance %0d, expected %0d", distance, want.edges));
          if (status !== want.stat)
            report($sformatf("status %0d, expected %0d", status, want.stat));
        end
      end
      if (start && !busy) begin
        want = '0;
        case (operation)
          itdq_pkg::OP_CLEAR: begin
            n_stored = 0;
            nest_top = 0;
            nest[0] = 0;
          end
          itdq_pkg::OP_ADD: want.stat = insert_interval(coord_a, coord_b);
          itdq_pkg::OP_QUERY: want.edges = DW'(edges_between(deepest_holder(coord_a),
                                                             deepest_holder(coord_b)));
          default: ;
        endcase
        answers_due = {answers_due, want};
      end
      pending = answers_due.size();
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int CAP        = 1024;
  localparam int CYCLE_CAP  = 1500000;

  logic        clk, rst, start, busy, done;
  logic [itdq_pkg::OP_W-1:0]     operation;
  logic [23:0]                   coord_a, coord_b;
  logic [itdq_pkg::DIST_W-1:0]   distance;
  logic [itdq_pkg::STATUS_W-1:0] status;
  int fail_count, pending, results_seen;
  int cycle_count;
  int idle_pct;
  int items_sent;
  int n_adds, n_queries;

  interval_tree_distance_query_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .coord_a(coord_a), .coord_b(coord_b), .done(done), .distance(distance),
    .status(status)
  );

  itdq_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .coord_a(coord_a), .coord_b(coord_b), .done(done), .distance(distance),
    .status(status), .fail_count(fail_count), .pending(pending),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // one command transfer, with random idle cycles ahead of it
  task automatic issue(input itdq_pkg::op_t op, input logic [23:0] a, input logic [23:0] b);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    coord_a   <= a;
    coord_b   <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (op == itdq_pkg::OP_ADD) n_adds++;
    if (op == itdq_pkg::OP_QUERY) n_queries++;
  endtask

  task automatic random_point(output logic [23:0] p);
    case ($urandom_range(3, 0))
      0: p = 24'($urandom_range(4095, 0));
      1: p = 24'hFFFFFF - 24'($urandom_range(15, 0));
      default: p = 24'($urandom);
    endcase
  endtask

  // intervals built by splitting and sibling jumps, mostly in sorted order, with random adds mixed in
  task automatic build_tree(input int count, input int queries);
    logic [23:0] l, r, span, p, q;
    l = 24'($urandom_range(1000, 0));
    r = 24'hFFFFFF - 24'($urandom_range(1000, 0));
    issue(itdq_pkg::OP_CLEAR, 24'($urandom), 24'($urandom));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9, 0) == 0) begin
        random_point(p);
        random_point(q);
        issue(itdq_pkg::OP_ADD, p, q);
      end
      span = r - l;
      if (span < 4 || $urandom_range(3, 0) == 0) begin
        // jump right to a fresh sibling region
        l = r + 24'($urandom_range(3, 1));
        if (l > 24'hFFFF00) l = 24'hFFFF00 - 24'($urandom_range(255, 0));
        r = l + 24'($urandom_range(200000, 2));
        if (r < l) r = 24'hFFFFFF;
      end else begin
        l = l + 24'($urandom_range(span / 8, 1));
        r = l + 24'($urandom_range((r - l) / 2, 1));
      end
      issue(itdq_pkg::OP_ADD, l, r);
    end
    for (int i = 0; i < queries; i++) begin
      random_point(p);
      random_point(q);
      issue(itdq_pkg::OP_QUERY, p, q);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    logic [23:0] p, q;
    start = 1'b0;
    operation = itdq_pkg::OP_CLEAR;
    coord_a = '0;
    coord_b = '0;
    idle_pct = 0;
    items_sent = 0;
    n_adds = 0;
    n_queries = 0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, malformed adds, unused code
    issue(itdq_pkg::OP_QUERY, 24'h000000, 24'hFFFFFF);
    issue(itdq_pkg::OP_ADD, 24'h000010, 24'h00000F);
    issue(itdq_pkg::OP_ADD, 24'h000000, 24'hFFFFFF);
    issue(itdq_pkg::OP_ADD, 24'h000001, 24'h000100);
    issue(itdq_pkg::OP_ADD, 24'h000002, 24'h000050);
    issue(itdq_pkg::OP_ADD, 24'h000060, 24'h000090);
    issue(itdq_pkg::OP_ADD, 24'h000001, 24'h000200);
    issue(itdq_pkg::OP_ADD, 24'h000080, 24'h000400);
    issue(itdq_pkg::OP_ADD, 24'h000080, 24'h000300);
    issue(itdq_pkg::OP_ADD, 24'h001000, 24'h001000);
    issue(itdq_pkg::OP_QUERY, 24'h000003, 24'h000070);
    issue(itdq_pkg::OP_QUERY, 24'h000003, 24'h001000);
    issue(itdq_pkg::OP_QUERY, 24'h000000, 24'hFFFFFF);
    issue(itdq_pkg::OP_QUERY, 24'h000090, 24'h000003);
    issue(itdq_pkg::OP_QUERY, 24'h000500, 24'h000500);
    issue(itdq_pkg::OP_RSVD, 24'hFFFFFF, 24'hFFFFFF);
    issue(itdq_pkg::OP_CLEAR, 24'hFFFFFF, 24'h000000);
    issue(itdq_pkg::OP_QUERY, 24'h000003, 24'h000070);

    // fill the table with a deep chain to reach full and long lifts
    issue(itdq_pkg::OP_CLEAR, 24'h0, 24'h0);
    for (int i = 0; i < CAP; i++)
      issue(itdq_pkg::OP_ADD, 24'(i * 16), 24'hFFFFFF - 24'(i * 16));
    issue(itdq_pkg::OP_ADD, 24'h00FFFF, 24'h010000);
    issue(itdq_pkg::OP_ADD, 24'h000000, 24'h000001);
    issue(itdq_pkg::OP_QUERY, 24'h000000, 24'h7FFFFF);
    issue(itdq_pkg::OP_QUERY, 24'hFFFFFF, 24'h800000);
    issue(itdq_pkg::OP_QUERY, 24'h003FF5, 24'h000011);

    // random phases with different idle rates
    for (int phase = 0; phase < 16; phase++) begin
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 67;
        2: idle_pct = 0;
        default: idle_pct = 33;
      endcase
      build_tree($urandom_range(30, 3), $urandom_range(20, 8));
      for (int i = 0; i < 4; i++) begin
        random_point(p);
        random_point(q);
        issue(itdq_pkg::op_t'(2'($urandom_range(3, 0))), p, q);
      end
    end
    idle_pct = 0;
    drain();

    $display("sent %0d commands (%0d adds, %0d queries), checked %0d results",
             items_sent, n_adds, n_queries, results_seen);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/itdq_pkg.sv
hw/rtl/itdq_ram.sv
hw/rtl/interval_tree_distance_query_top.sv
sim/itdq_checker.sv
sim/tb_top.sv
